>>> design/rch_pkg.sv
// shared constants and types for the rgb channel histogram
package rch_pkg;

    localparam int BIN_COUNT_DEF   = 64;
    localparam int COUNT_WIDTH_DEF = 21;
    localparam int PIX_W           = 8;
    localparam int FRAC_BITS       = 16;
    localparam int FRAC_W          = FRAC_BITS + 1;
    localparam int NUM_CH          = 3;
    localparam int QUEUE_DEPTH     = 4;

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

>>> design/rch_pixel_if.sv
// pixel request channel
interface rch_pixel_if;

    logic                       valid;
    logic                       ready;
    logic [rch_pkg::PIX_W-1:0]  blue_value;
    logic [rch_pkg::PIX_W-1:0]  green_value;
    logic [rch_pkg::PIX_W-1:0]  red_value;
    logic                       last_pixel;

    modport source (
        output valid, blue_value, green_value, red_value, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, blue_value, green_value, red_value, last_pixel,
        output ready
    );

endinterface

>>> design/rch_result_if.sv
// histogram result channel
interface rch_result_if #(
    parameter int BIN_W = $clog2(rch_pkg::BIN_COUNT_DEF)
);

    logic                       valid;
    logic                       ready;
    logic [BIN_W-1:0]           bin_index;
    logic [rch_pkg::FRAC_W-1:0] blue_fraction;
    logic [rch_pkg::FRAC_W-1:0] green_fraction;
    logic [rch_pkg::FRAC_W-1:0] red_fraction;
    logic                       count_overflow;
    logic                       last_bin;

    modport source (
        output valid, bin_index, blue_fraction, green_fraction, red_fraction,
               count_overflow, last_bin,
        input  ready
    );

    modport sink (
        input  valid, bin_index, blue_fraction, green_fraction, red_fraction,
               count_overflow, last_bin,
        output ready
    );

endinterface

>>> design/rch_front.sv
// front end: pixel to bin classification and the request queue
module rch_front #(
    parameter int BIN_COUNT = rch_pkg::BIN_COUNT_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    rch_pixel_if.sink                                    i_pix,
    output logic                                         o_q_valid,
    input  logic                                         i_q_ready,
    output logic [rch_pkg::NUM_CH*$clog2(BIN_COUNT):0]   o_q_data
);

    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int PROD_W = rch_pkg::PIX_W + $clog2(BIN_COUNT + 1);
    localparam int Q_W    = rch_pkg::NUM_CH * BIN_W + 1;
    localparam int PTR_W  = $clog2(rch_pkg::QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(rch_pkg::QUEUE_DEPTH + 1);

    logic [rch_pkg::PIX_W-1:0] pix [rch_pkg::NUM_CH];
    logic [PROD_W-1:0]         prod [rch_pkg::NUM_CH];
    logic [Q_W-1:0]            item;

    logic [Q_W-1:0]   r_q [rch_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign pix[rch_pkg::CH_BLUE]  = i_pix.blue_value;
    assign pix[rch_pkg::CH_GREEN] = i_pix.green_value;
    assign pix[rch_pkg::CH_RED]   = i_pix.red_value;

    // bin = (value * bins) >> 8
    always_comb begin
        item = '0;
        for (int ch = 0; ch < rch_pkg::NUM_CH; ch++) begin
            prod[ch] = PROD_W'(pix[ch]) * PROD_W'(BIN_COUNT);
            item[ch*BIN_W +: BIN_W] = BIN_W'(prod[ch] >> rch_pkg::PIX_W);
        end
        item[Q_W-1] = i_pix.last_pixel;
    end

    assign i_pix.ready = (r_cnt != CNT_W'(rch_pkg::QUEUE_DEPTH));
    assign push        = i_pix.valid && i_pix.ready;
    assign o_q_valid   = (r_cnt != '0);
    assign pop         = o_q_valid && i_q_ready;
    assign o_q_data    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

>>> design/rch_div.sv
// three-lane radix-2 fraction divider, one quotient bit per cycle
module rch_div #(
    parameter int COUNT_WIDTH = rch_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [COUNT_WIDTH-1:0]      i_cnt [rch_pkg::NUM_CH],
    input  logic [COUNT_WIDTH-1:0]      i_divisor,
    output rch_pkg::t_div_status        o_status,
    output logic [rch_pkg::FRAC_W-1:0]  o_quot [rch_pkg::NUM_CH]
);

    localparam int STEP_W = $clog2(rch_pkg::FRAC_W);

    logic [STEP_W-1:0]          r_step;
    logic                       r_busy;
    logic                       r_done;
    logic [COUNT_WIDTH-1:0]     r_div;
    logic [COUNT_WIDTH-1:0]     r_rem  [rch_pkg::NUM_CH];
    logic [rch_pkg::FRAC_W-1:0] r_quot [rch_pkg::NUM_CH];

    logic [COUNT_WIDTH:0]       trial [rch_pkg::NUM_CH];
    logic                       ge    [rch_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0]     n_rem [rch_pkg::NUM_CH];

    // first step compares the count itself, later steps the doubled remainder
    always_comb begin
        for (int ch = 0; ch < rch_pkg::NUM_CH; ch++) begin
            trial[ch] = (r_step == '0) ? {1'b0, r_rem[ch]} : {r_rem[ch], 1'b0};
            ge[ch]    = (trial[ch] >= {1'b0, r_div});
            n_rem[ch] = ge[ch] ? COUNT_WIDTH'(trial[ch] - {1'b0, r_div})
                               : COUNT_WIDTH'(trial[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(rch_pkg::FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            for (int ch = 0; ch < rch_pkg::NUM_CH; ch++) begin
                r_rem[ch] <= i_cnt[ch];
            end
        end else if (r_busy) begin
            for (int ch = 0; ch < rch_pkg::NUM_CH; ch++) begin
                r_rem[ch]  <= n_rem[ch];
                r_quot[ch] <= {r_quot[ch][rch_pkg::FRAC_W-2:0], ge[ch]};
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule

>>> design/rch_back.sv
// back end: bin count memories, pixel total and result sequencer
module rch_back #(
    parameter int BIN_COUNT   = rch_pkg::BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = rch_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_q_valid,
    output logic                                         o_q_ready,
    input  logic [rch_pkg::NUM_CH*$clog2(BIN_COUNT):0]   i_q_data,
    rch_result_if.source                                 o_res
);

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int Q_W   = rch_pkg::NUM_CH * BIN_W + 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [BIN_W-1:0]       LAST_K  = BIN_W'(BIN_COUNT - 1);

    typedef enum logic [4:0] {
        S_ACC = 5'b00001,
        S_RD  = 5'b00010,
        S_LD  = 5'b00100,
        S_DIV = 5'b01000,
        S_OUT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                       r_v1;
    logic                       r_last1;
    logic [BIN_W-1:0]           r_bin1    [rch_pkg::NUM_CH];
    logic                       r_fwd_v;
    logic [BIN_W-1:0]           r_fwd_bin [rch_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0]     r_fwd_val [rch_pkg::NUM_CH];
    logic [BIN_COUNT-1:0]       r_vld     [rch_pkg::NUM_CH];
    logic                       r_rd_vld  [rch_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0]     r_total;
    logic                       r_ovf;
    logic [BIN_W-1:0]           r_k;
    logic                       r_out_valid;
    logic [BIN_W-1:0]           r_out_bin;
    logic [rch_pkg::FRAC_W-1:0] r_out_frac [rch_pkg::NUM_CH];
    logic                       r_out_ovf;
    logic                       r_out_last;

    logic                       q_pop;
    logic [BIN_W-1:0]           rd_addr  [rch_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0]     rd_data  [rch_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0]     cur      [rch_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0]     upd      [rch_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0]     div_cnt  [rch_pkg::NUM_CH];
    logic [rch_pkg::FRAC_W-1:0] div_quot [rch_pkg::NUM_CH];
    logic                       bin_sat;
    logic                       tot_sat;
    logic                       out_take;
    logic                       clear;
    logic                       div_start;
    rch_pkg::t_div_status       div_st;

    // new requests only in the accumulate state, none while the last pixel of an image is being counted
    assign o_q_ready = (r_state == S_ACC) && !(r_v1 && r_last1);
    assign q_pop     = i_q_valid && o_q_ready;
    assign out_take  = r_out_valid && o_res.ready;
    assign clear     = out_take && r_out_last;
    assign div_start = (r_state == S_LD);
    assign tot_sat   = (r_total == CNT_MAX);

    always_comb begin
        bin_sat = 1'b0;
        for (int ch = 0; ch < rch_pkg::NUM_CH; ch++) begin
            rd_addr[ch] = (r_state == S_ACC) ? i_q_data[ch*BIN_W +: BIN_W] : r_k;
            // forward the count just written by the preceding update when it went to the same bin
            if (r_fwd_v && (r_fwd_bin[ch] == r_bin1[ch])) begin
                cur[ch] = r_fwd_val[ch];
            end else begin
                cur[ch] = r_rd_vld[ch] ? rd_data[ch] : '0;
            end
            upd[ch]     = (cur[ch] == CNT_MAX) ? cur[ch] : cur[ch] + 1'b1;
            bin_sat     = bin_sat | (cur[ch] == CNT_MAX);
            div_cnt[ch] = r_rd_vld[ch] ? rd_data[ch] : '0;
        end
    end

    for (genvar ch = 0; ch < rch_pkg::NUM_CH; ch++) begin : g_ch
        logic [COUNT_WIDTH-1:0] r_mem [BIN_COUNT];
        logic [COUNT_WIDTH-1:0] r_rd_data;

        always_ff @(posedge i_clk) begin
            if (r_v1) begin
                r_mem[r_bin1[ch]] <= upd[ch];
            end
            r_rd_data <= r_mem[rd_addr[ch]];
        end

        assign rd_data[ch] = r_rd_data;
    end

    // valid bits stand in for clearing the memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            for (int ch = 0; ch < rch_pkg::NUM_CH; ch++) begin
                r_vld[ch] <= '0;
            end
        end else if (r_v1) begin
            for (int ch = 0; ch < rch_pkg::NUM_CH; ch++) begin
                r_vld[ch][r_bin1[ch]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < rch_pkg::NUM_CH; ch++) begin
            r_rd_vld[ch] <= r_vld[ch][rd_addr[ch]];
            if (q_pop) begin
                r_bin1[ch] <= i_q_data[ch*BIN_W +: BIN_W];
            end
            if (r_v1) begin
                r_fwd_bin[ch] <= r_bin1[ch];
                r_fwd_val[ch] <= upd[ch];
            end
        end
        if (q_pop) begin
            r_last1 <= i_q_data[Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_fwd_v <= 1'b0;
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_v1    <= q_pop;
            r_fwd_v <= r_v1;
            if (clear) begin
                r_total <= '0;
                r_ovf   <= 1'b0;
            end else if (r_v1) begin
                r_total <= tot_sat ? r_total : r_total + 1'b1;
                r_ovf   <= r_ovf | tot_sat | bin_sat;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC: begin
                if (r_v1 && r_last1) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_st.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_take) begin
                    n_state = r_out_last ? S_ACC : S_RD;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_k <= '0;
            end else if (out_take && !r_out_last) begin
                r_k <= r_k + 1'b1;
            end
            if (div_st.done) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_st.done) begin
            r_out_bin  <= r_k;
            r_out_frac <= div_quot;
            r_out_ovf  <= r_ovf;
            r_out_last <= (r_k == LAST_K);
        end
    end

    rch_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_cnt     (div_cnt),
        .i_divisor (r_total),
        .o_status  (div_st),
        .o_quot    (div_quot)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.bin_index      = r_out_bin;
    assign o_res.blue_fraction  = r_out_frac[rch_pkg::CH_BLUE];
    assign o_res.green_fraction = r_out_frac[rch_pkg::CH_GREEN];
    assign o_res.red_fraction   = r_out_frac[rch_pkg::CH_RED];
    assign o_res.count_overflow = r_out_ovf;
    assign o_res.last_bin       = r_out_last;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_fwd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_v |-> (r_fwd_val[rch_pkg::CH_BLUE] <= r_total &&
                     r_fwd_val[rch_pkg::CH_GREEN] <= r_total &&
                     r_fwd_val[rch_pkg::CH_RED] <= r_total))
        else $error("bin count above pixel total");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> (r_total == '0 && !r_ovf && r_state == S_ACC))
        else $error("counters not cleared after the final bin");

endmodule

>>> design/rgb_channel_histogram.sv
// rgb channel histogram top level
// pixels: one request per cycle while counting; queue, then bin register, then count update
// a four-entry queue keeps taking pixels, until full, while the back end is busy or emitting
// emission: per bin one memory read, a 17-step shared divider and the output register,
// 64 bins per image, the next bin starting once the current result is taken
// reset: synchronous active low, counts read as zero through per-bin valid bits at once
module rgb_channel_histogram #(
    parameter int BIN_COUNT   = rch_pkg::BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = rch_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rch_pixel_if.sink     i_pix,
    rch_result_if.source  o_res
);

    localparam int Q_W = rch_pkg::NUM_CH * $clog2(BIN_COUNT) + 1;

    logic           q_valid;
    logic           q_ready;
    logic [Q_W-1:0] q_data;

    rch_front #(
        .BIN_COUNT (BIN_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_data  (q_data)
    );

    rch_back #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_data  (q_data),
        .o_res     (o_res)
    );

endmodule

>>> test/rgb_channel_histogram_tb.sv
// self-checking testbench for rgb_channel_histogram: directed and random images, per-bin checks
module rgb_channel_histogram_tb;

    localparam int BINS         = rch_pkg::BIN_COUNT_DEF;
    localparam int CNT_W        = rch_pkg::COUNT_WIDTH_DEF;
    localparam int PIX_W        = rch_pkg::PIX_W;
    localparam int FRAC_W       = rch_pkg::FRAC_W;
    localparam int FRAC_BITS    = rch_pkg::FRAC_BITS;
    localparam int BIN_W        = $clog2(BINS);
    localparam int RANDOM_ITEMS = 430;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS  = 10;
    localparam int HALF_PERIOD  = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_BITS;

    typedef enum logic [1:0] {
        PH_RX_SLOW,
        PH_TX_SLOW,
        PH_FULL_RATE
    } t_idle_phase;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             last;
    } t_pixel;

    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [FRAC_W-1:0] blue;
        logic [FRAC_W-1:0] green;
        logic [FRAC_W-1:0] red;
        logic              overflow;
        logic              last;
    } t_bin_result;

    logic i_clk;
    logic i_rst_n;

    rch_pixel_if                   pix_if ();
    rch_result_if #(.BIN_W(BIN_W)) res_if ();

    rgb_channel_histogram #(
        .BIN_COUNT   (BINS),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    // predictor state
    logic [CNT_W-1:0] blue_cnt  [BINS];
    logic [CNT_W-1:0] green_cnt [BINS];
    logic [CNT_W-1:0] red_cnt   [BINS];
    logic [CNT_W-1:0] pixel_cnt;
    logic             overflow_flag;

    t_pixel      pixel_q[$];
    t_bin_result bin_result_q[$];

    int unsigned total_items;
    int unsigned pix_presented;
    int unsigned pix_accepted;
    int unsigned res_checked;
    int unsigned images_done;
    int unsigned mismatches;
    int unsigned idle_cycles;

    function automatic int bin_of(input logic [PIX_W-1:0] v);
        return (int'(v) * BINS) >> PIX_W;
    endfunction

    function automatic logic [CNT_W:0] bump(input logic [CNT_W-1:0] c);
        if (c == CNT_MAX) begin
            return {1'b1, c};
        end
        return {1'b0, c + 1'b1};
    endfunction

    function automatic logic [FRAC_W-1:0] frac_of(input logic [CNT_W-1:0] c,
                                                  input logic [CNT_W-1:0] total);
        longint unsigned cw;
        longint unsigned tw;
        longint unsigned q;
        cw = c;
        tw = total;
        if (tw == 0) begin
            return '0;
        end
        q = (cw << FRAC_BITS) / tw;
        if (q > FRAC_ONE) begin
            q = FRAC_ONE;
        end
        return q[FRAC_W-1:0];
    endfunction

    task automatic count_pixel(input t_pixel p);
        logic [CNT_W:0] nb;
        logic [CNT_W:0] ng;
        logic [CNT_W:0] nr;
        logic [CNT_W:0] np;
        int             bb;
        int             gb;
        int             rb;
        t_bin_result    r;
        bb = bin_of(p.blue);
        gb = bin_of(p.green);
        rb = bin_of(p.red);
        nb = bump(blue_cnt[bb]);
        ng = bump(green_cnt[gb]);
        nr = bump(red_cnt[rb]);
        np = bump(pixel_cnt);
        blue_cnt[bb]  = nb[CNT_W-1:0];
        green_cnt[gb] = ng[CNT_W-1:0];
        red_cnt[rb]   = nr[CNT_W-1:0];
        pixel_cnt     = np[CNT_W-1:0];
        overflow_flag = overflow_flag | nb[CNT_W] | ng[CNT_W] | nr[CNT_W] | np[CNT_W];
        if (p.last) begin
            for (int k = 0; k < BINS; k++) begin
                r.bin      = BIN_W'(k);
                r.blue     = frac_of(blue_cnt[k], pixel_cnt);
                r.green    = frac_of(green_cnt[k], pixel_cnt);
                r.red      = frac_of(red_cnt[k], pixel_cnt);
                r.overflow = overflow_flag;
                r.last     = (k == BINS - 1);
                bin_result_q.push_back(r);
            end
            for (int k = 0; k < BINS; k++) begin
                blue_cnt[k]  = '0;
                green_cnt[k] = '0;
                red_cnt[k]   = '0;
            end
            pixel_cnt     = '0;
            overflow_flag = 1'b0;
            images_done++;
        end
    endtask

    task automatic push_pixel(input int b, input int g, input int r, input bit l);
        t_pixel p;
        p.blue  = PIX_W'(b);
        p.green = PIX_W'(g);
        p.red   = PIX_W'(r);
        p.last  = l;
        pixel_q.push_back(p);
    endtask

    function automatic int pick_value(input int base, input bit skewed);
        int corner [6] = '{0, 3, 4, 251, 252, 255};
        if (skewed && $urandom_range(3) != 0) begin
            return base;
        end
        if ($urandom_range(4) == 0) begin
            return corner[$urandom_range(5)];
        end
        return $urandom_range(255);
    endfunction

    function automatic t_idle_phase cur_phase();
        if (pix_accepted < total_items / 3) begin
            return PH_RX_SLOW;
        end
        if (pix_accepted < (2 * total_items) / 3) begin
            return PH_TX_SLOW;
        end
        return PH_FULL_RATE;
    endfunction

    function automatic bit tx_idles();
        case (cur_phase())
            PH_RX_SLOW: return $urandom_range(99) < 11;
            PH_TX_SLOW: return $urandom_range(99) < 51;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic bit rx_idles();
        case (cur_phase())
            PH_RX_SLOW: return $urandom_range(99) < 51;
            PH_TX_SLOW: return $urandom_range(99) < 11;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic bit all_done();
        return pixel_q.size() == 0 && pix_accepted == total_items &&
               bin_result_q.size() == 0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    // driver: requests and result ready change on the falling edge
    always @(negedge i_clk) begin : pixel_driver
        t_pixel nxt;
        if (i_rst_n) begin
            if (!pix_if.valid || pix_presented == pix_accepted) begin
                if (pixel_q.size() > 0 && !tx_idles()) begin
                    nxt = pixel_q.pop_front();
                    pix_if.valid       <= 1'b1;
                    pix_if.blue_value  <= nxt.blue;
                    pix_if.green_value <= nxt.green;
                    pix_if.red_value   <= nxt.red;
                    pix_if.last_pixel  <= nxt.last;
                    pix_presented      <= pix_presented + 1;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
            res_if.ready <= !rx_idles();
        end
    end

    // monitor: results checked before the same edge's request is counted
    always @(posedge i_clk) begin : histogram_monitor
        t_bin_result got;
        t_bin_result want;
        t_pixel      seen;
        bit          bad;
        bit          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (res_if.valid && res_if.ready) begin
                moved        = 1'b1;
                got.bin      = res_if.bin_index;
                got.blue     = res_if.blue_fraction;
                got.green    = res_if.green_fraction;
                got.red      = res_if.red_fraction;
                got.overflow = res_if.count_overflow;
                got.last     = res_if.last_bin;
                if (bin_result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: bin %0d b %0d g %0d r %0d ovf %0b last %0b",
                                 got.bin, got.blue, got.green, got.red, got.overflow,
                                 got.last);
                    end
                end else begin
                    want = bin_result_q.pop_front();
                    bad  = (got.bin !== want.bin) || (got.blue !== want.blue) ||
                           (got.green !== want.green) || (got.red !== want.red) ||
                           (got.overflow !== want.overflow) || (got.last !== want.last);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch on result %0d", res_checked);
                            $display("  expected bin %0d b %0d g %0d r %0d ovf %0b last %0b",
                                     want.bin, want.blue, want.green, want.red,
                                     want.overflow, want.last);
                            $display("  actual   bin %0d b %0d g %0d r %0d ovf %0b last %0b",
                                     got.bin, got.blue, got.green, got.red,
                                     got.overflow, got.last);
                        end
                    end
                end
                res_checked++;
            end
            if (pix_if.valid && pix_if.ready) begin
                moved       = 1'b1;
                seen.blue   = pix_if.blue_value;
                seen.green  = pix_if.green_value;
                seen.red    = pix_if.red_value;
                seen.last   = pix_if.last_pixel;
                count_pixel(seen);
                pix_accepted++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int n_img;
        int base_b;
        int base_g;
        int base_r;
        bit skewed;
        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.blue_value  = '0;
        pix_if.green_value = '0;
        pix_if.red_value   = '0;
        pix_if.last_pixel  = 1'b0;
        res_if.ready       = 1'b0;
        pix_presented      = 0;
        pix_accepted       = 0;
        res_checked        = 0;
        images_done        = 0;
        mismatches         = 0;
        idle_cycles        = 0;
        pixel_cnt          = '0;
        overflow_flag      = 1'b0;
        for (int k = 0; k < BINS; k++) begin
            blue_cnt[k]  = '0;
            green_cnt[k] = '0;
            red_cnt[k]   = '0;
        end

        // single-pixel image, every fraction is zero or one
        push_pixel(0, 255, 128, 1'b1);
        // bin edges and thirds
        push_pixel(3, 4, 251, 1'b0);
        push_pixel(252, 255, 0, 1'b0);
        push_pixel(127, 128, 63, 1'b1);
        // sweep of sixteen pixels across the range
        for (int k = 0; k < 16; k++) begin
            push_pixel(k * 17, 255 - k * 17, (k * 17) ^ 8'hA5, k == 15);
        end

        while (pixel_q.size() < RANDOM_ITEMS) begin
            n_img  = ($urandom_range(9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 24);
            if (n_img > RANDOM_ITEMS - pixel_q.size()) begin
                n_img = RANDOM_ITEMS - pixel_q.size();
            end
            skewed = ($urandom_range(3) == 0);
            base_b = $urandom_range(255);
            base_g = $urandom_range(255);
            base_r = $urandom_range(255);
            for (int k = 0; k < n_img; k++) begin
                push_pixel(pick_value(base_b, skewed), pick_value(base_g, skewed),
                           pick_value(base_r, skewed), k == n_img - 1);
            end
        end
        total_items = pixel_q.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!all_done() && idle_cycles < STALL_LIMIT) @(posedge i_clk);
        if (idle_cycles < STALL_LIMIT) begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end

        if (idle_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results still pending",
                     idle_cycles, bin_result_q.size());
            $display("Testbench completed WITH ERRORS");
        end else begin
            $display("sent %0d pixels in %0d images, checked %0d bin results",
                     pix_accepted, images_done, res_checked);
            $display("idle mixes: slow receiver, slow sender, full rate; %0d mismatches",
                     mismatches);
            if (mismatches == 0) begin
                $display("Testbench completed without errors");
            end else begin
                $display("Testbench completed WITH ERRORS");
            end
        end
        $finish;
    end

endmodule

>>> files.f
design/rch_pkg.sv
design/rch_pixel_if.sv
design/rch_result_if.sv
design/rch_front.sv
design/rch_div.sv
design/rch_back.sv
design/rgb_channel_histogram.sv
test/rgb_channel_histogram_tb.sv
